@@ rtl/bpskdf_pkg.sv @@
// ----------------------------------------------------------------------------
// bpskdf_pkg
// Shared types and constants of the bpsk slicer and packet deframer.
// ----------------------------------------------------------------------------
package bpskdf_pkg;

   // defaults for the top-level parameters
   localparam int SAMPLE_BITS_DEF   = 16;
   localparam int POSITION_BITS_DEF = 32;

   // width of the sample fields on the request channel
   localparam int SAMPLE_FIELD_BITS = 16;

   // slice queue between front end and deframer
   localparam int QUEUE_DEPTH = 4;

   // configuration port
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [7:0]  SYNC_RESET = 8'hD5;
   localparam logic [15:0] CRC_POLY   = 16'h1021;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;

   typedef enum logic [1:0] {
      CSR_AXIS_SELECT     = 2'd0,
      CSR_INVERT_POLARITY = 2'd1,
      CSR_SYNC_BYTE       = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD   = 2'd0,
      KIND_COMPLETE  = 2'd1,
      KIND_TRUNCATED = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_SEQ_LO  = 3'd1,
      PH_SEQ_HI  = 3'd2,
      PH_LEN     = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CRC_LO  = 3'd5,
      PH_CRC_HI  = 3'd6
   } phase_type;

   typedef struct packed {
      logic       axis_select;
      logic       invert_polarity;
      logic [7:0] sync_byte;
   } cfg_type;

   // one sliced symbol travelling from front end to deframer
   typedef struct packed {
      logic data_bit;
      logic end_of_capture;
   } slice_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [7:0]  data_byte;
      logic [15:0] sequence_number;
      logic [7:0]  payload_length;
      logic [15:0] crc_received;
      logic [15:0] crc_computed;
      logic        crc_match;
      logic [31:0] sync_bit_position;
      logic [8:0]  bytes_after_sync;
   } rsp_type;

endpackage

@@ rtl/bpskdf_ifs.sv @@
// ----------------------------------------------------------------------------
// bpskdf channel interfaces
// Sample request channel and deframer response channel, valid/ready.
// ----------------------------------------------------------------------------
interface bpskdf_req_if;
   logic                                             valid;
   logic                                             ready;
   logic signed [bpskdf_pkg::SAMPLE_FIELD_BITS-1:0] sample_i;
   logic signed [bpskdf_pkg::SAMPLE_FIELD_BITS-1:0] sample_q;
   logic                                             end_of_capture;

   modport source (output valid, output sample_i, output sample_q,
                   output end_of_capture, input ready);
   modport sink   (input valid, input sample_i, input sample_q,
                   input end_of_capture, output ready);
endinterface

interface bpskdf_rsp_if;
   logic                  valid;
   logic                  ready;
   bpskdf_pkg::kind_type  result_kind;
   logic [7:0]            data_byte;
   logic [15:0]           sequence_number;
   logic [7:0]            payload_length;
   logic [15:0]           crc_received;
   logic [15:0]           crc_computed;
   logic                  crc_match;
   logic [31:0]           sync_bit_position;
   logic [8:0]            bytes_after_sync;

   modport source (output valid, output result_kind, output data_byte,
                   output sequence_number, output payload_length,
                   output crc_received, output crc_computed, output crc_match,
                   output sync_bit_position, output bytes_after_sync,
                   input ready);
   modport sink   (input valid, input result_kind, input data_byte,
                   input sequence_number, input payload_length,
                   input crc_received, input crc_computed, input crc_match,
                   input sync_bit_position, input bytes_after_sync,
                   output ready);
endinterface

@@ rtl/bpskdf_front.sv @@
// ----------------------------------------------------------------------------
// bpskdf_front
// Accepts samples and slices the selected axis to one bit by its sign.
// ----------------------------------------------------------------------------
module bpskdf_front #(
   parameter int SAMPLE_BITS = bpskdf_pkg::SAMPLE_BITS_DEF
) (
   input  bpskdf_pkg::cfg_type   cfg,
   bpskdf_req_if.sink            req,
   output logic                  push_valid,
   output bpskdf_pkg::slice_type push_data,
   input  logic                  push_ready
);

   localparam int FIELD_BITS = bpskdf_pkg::SAMPLE_FIELD_BITS;
   localparam int WIDE_BITS  = (SAMPLE_BITS > FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;

   logic [FIELD_BITS-1:0]  chosen;
   logic [WIDE_BITS-1:0]   chosen_wide;
   logic [SAMPLE_BITS-1:0] sample;
   logic                   negative;
   logic                   nonzero;

   // the low SAMPLE_BITS of the field form the sample, zero-filled above it
   always_comb begin
      chosen      = cfg.axis_select ? req.sample_q : req.sample_i;
      chosen_wide = WIDE_BITS'(chosen);
      sample      = chosen_wide[SAMPLE_BITS-1:0];
      negative    = sample[SAMPLE_BITS-1];
      nonzero     = |sample;
   end

   // inverted: strictly positive gives one, zero gives zero either way
   always_comb begin
      push_data.data_bit       = cfg.invert_polarity ? (!negative && nonzero) : negative;
      push_data.end_of_capture = req.end_of_capture;
      push_valid               = req.valid;
      req.ready                = push_ready;
   end

endmodule

@@ rtl/bpskdf_queue.sv @@
// ----------------------------------------------------------------------------
// bpskdf_queue
// Short queue of sliced symbols between front end and deframer.
// ----------------------------------------------------------------------------
module bpskdf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  bpskdf_pkg::slice_type push_data,
   output logic                  push_ready,
   output logic                  pop_valid,
   output bpskdf_pkg::slice_type pop_data,
   input  logic                  pop_ready
);

   localparam int DEPTH    = bpskdf_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

   bpskdf_pkg::slice_type entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  push, pop;

   always_comb begin
      push_ready = (count_ff != CNT_BITS'(DEPTH));
      pop_valid  = (count_ff != '0);
      pop_data   = entry_ff[rd_ptr_ff];
      push       = push_valid && push_ready;
      pop        = pop_valid && pop_ready;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("queue fill above depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");

endmodule

@@ rtl/bpskdf_back.sv @@
// ----------------------------------------------------------------------------
// bpskdf_back
// Sync hunt, byte assembly, payload crc and result register.
// ----------------------------------------------------------------------------
module bpskdf_back #(
   parameter int POSITION_BITS = bpskdf_pkg::POSITION_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bpskdf_pkg::cfg_type   cfg,
   input  logic                  pop_valid,
   input  bpskdf_pkg::slice_type pop_data,
   output logic                  pop_ready,
   bpskdf_rsp_if.source          rsp
);

   localparam logic [POSITION_BITS-1:0] SYNC_SPAN = POSITION_BITS'(7);

   bpskdf_pkg::phase_type    phase_ff, phase_in, phase_step;
   logic [7:0]               window_ff, window_in;
   logic [3:0]               fill_ff, fill_in;
   logic [2:0]               bit_idx_ff, bit_idx_in;
   logic [7:0]               shift_ff, shift_in;
   logic [15:0]              seq_ff, seq_in;
   logic [7:0]               len_ff, len_in;
   logic [7:0]               pcount_ff, pcount_in;
   logic [15:0]              crc_ff, crc_in;
   logic [7:0]               crc_lo_ff, crc_lo_in;
   logic [8:0]               rcount_ff, rcount_in;
   logic [POSITION_BITS-1:0] gbc_ff, gbc_in;
   logic [POSITION_BITS-1:0] syncpos_ff, syncpos_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   bpskdf_pkg::rsp_type      rsp_ff, rsp_in;

   logic        step, bit_b, eoc, hit, byte_done;
   logic        give_payload, give_complete, give_truncated;
   logic [7:0]  window_shift, byte_val, pcount_inc;
   logic [15:0] crc_next, crc_rx;

   always_comb begin
      pop_ready    = !rsp_valid_ff || rsp.ready;
      step         = pop_valid && pop_ready;
      bit_b        = pop_data.data_bit;
      eoc          = pop_data.end_of_capture;
      window_shift = {window_ff[6:0], bit_b};
      byte_val     = {shift_ff[6:0], bit_b};
      pcount_inc   = pcount_ff + 8'd1;
      // window counts as full once the eighth bit enters it
      hit          = (phase_ff == bpskdf_pkg::PH_HUNT) && (fill_ff >= 4'd7) &&
                     (window_shift == cfg.sync_byte);
      byte_done    = (phase_ff != bpskdf_pkg::PH_HUNT) && (bit_idx_ff == 3'd7);
      crc_next     = {crc_ff[14:0], 1'b0} ^
                     ((crc_ff[15] ^ bit_b) ? bpskdf_pkg::CRC_POLY : 16'h0000);
      crc_rx       = {byte_val, crc_lo_ff};
   end

   // next parse phase
   always_comb begin
      phase_step = phase_ff;
      unique case (phase_ff)
         bpskdf_pkg::PH_HUNT: begin
            if (hit) phase_step = bpskdf_pkg::PH_SEQ_LO;
         end
         bpskdf_pkg::PH_SEQ_LO: begin
            if (byte_done) phase_step = bpskdf_pkg::PH_SEQ_HI;
         end
         bpskdf_pkg::PH_SEQ_HI: begin
            if (byte_done) phase_step = bpskdf_pkg::PH_LEN;
         end
         bpskdf_pkg::PH_LEN: begin
            if (byte_done) begin
               phase_step = (byte_val != 8'd0) ? bpskdf_pkg::PH_PAYLOAD
                                               : bpskdf_pkg::PH_CRC_LO;
            end
         end
         bpskdf_pkg::PH_PAYLOAD: begin
            if (byte_done && (pcount_inc == len_ff)) phase_step = bpskdf_pkg::PH_CRC_LO;
         end
         bpskdf_pkg::PH_CRC_LO: begin
            if (byte_done) phase_step = bpskdf_pkg::PH_CRC_HI;
         end
         bpskdf_pkg::PH_CRC_HI: begin
            if (byte_done) phase_step = bpskdf_pkg::PH_HUNT;
         end
         default: phase_step = bpskdf_pkg::PH_HUNT;
      endcase
      phase_in = phase_ff;
      if (step) begin
         phase_in = eoc ? bpskdf_pkg::PH_HUNT : phase_step;
      end
   end

   // datapath updates and result
   always_comb begin
      window_in  = window_ff;
      fill_in    = fill_ff;
      bit_idx_in = bit_idx_ff;
      shift_in   = shift_ff;
      seq_in     = seq_ff;
      len_in     = len_ff;
      pcount_in  = pcount_ff;
      crc_in     = crc_ff;
      crc_lo_in  = crc_lo_ff;
      rcount_in  = rcount_ff;
      gbc_in     = gbc_ff;
      syncpos_in = syncpos_ff;

      give_payload   = step && byte_done && (phase_ff == bpskdf_pkg::PH_PAYLOAD);
      give_complete  = step && byte_done && (phase_ff == bpskdf_pkg::PH_CRC_HI);
      give_truncated = step && eoc &&
                       ((phase_step == bpskdf_pkg::PH_PAYLOAD) ||
                        (phase_step == bpskdf_pkg::PH_CRC_LO) ||
                        (phase_step == bpskdf_pkg::PH_CRC_HI));

      if (step) begin
         gbc_in = gbc_ff + POSITION_BITS'(1);
         if (phase_ff == bpskdf_pkg::PH_HUNT) begin
            window_in = window_shift;
            if (fill_ff < 4'd8) fill_in = fill_ff + 4'd1;
            if (hit) begin
               syncpos_in = gbc_ff - SYNC_SPAN;
               bit_idx_in = '0;
               shift_in   = '0;
               seq_in     = '0;
               len_in     = '0;
               pcount_in  = '0;
               crc_in     = bpskdf_pkg::CRC_INIT;
               crc_lo_in  = '0;
               rcount_in  = '0;
            end
         end else begin
            if (phase_ff == bpskdf_pkg::PH_PAYLOAD) crc_in = crc_next;
            if (byte_done) begin
               bit_idx_in = '0;
               shift_in   = '0;
               rcount_in  = rcount_ff + 9'd1;
               case (phase_ff)
                  bpskdf_pkg::PH_SEQ_LO:  seq_in = {8'h00, byte_val};
                  bpskdf_pkg::PH_SEQ_HI:  seq_in = {byte_val, seq_ff[7:0]};
                  bpskdf_pkg::PH_LEN:     len_in = byte_val;
                  bpskdf_pkg::PH_PAYLOAD: pcount_in = pcount_inc;
                  bpskdf_pkg::PH_CRC_LO:  crc_lo_in = byte_val;
                  bpskdf_pkg::PH_CRC_HI: begin
                     window_in = '0;
                     fill_in   = '0;
                  end
                  default: ;
               endcase
            end else begin
               bit_idx_in = bit_idx_ff + 3'd1;
               shift_in   = byte_val;
            end
         end
      end

      // report fields are taken after this step, before any capture flush
      rsp_in.result_kind       = give_truncated ? bpskdf_pkg::KIND_TRUNCATED :
                                 give_complete  ? bpskdf_pkg::KIND_COMPLETE :
                                                  bpskdf_pkg::KIND_PAYLOAD;
      rsp_in.data_byte         = (give_payload && !give_truncated) ? byte_val : 8'h00;
      rsp_in.sequence_number   = seq_in;
      rsp_in.payload_length    = len_in;
      rsp_in.crc_received      = (give_complete && !give_truncated) ? crc_rx : 16'h0000;
      rsp_in.crc_computed      = (give_complete && !give_truncated) ? crc_ff : 16'h0000;
      rsp_in.crc_match         = give_complete && !give_truncated && (crc_rx == crc_ff);
      rsp_in.sync_bit_position = 32'(syncpos_in);
      rsp_in.bytes_after_sync  = rcount_in;

      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (step) rsp_valid_in = give_payload || give_complete || give_truncated;

      if (step && eoc) begin
         window_in  = '0;
         fill_in    = '0;
         bit_idx_in = '0;
         shift_in   = '0;
         seq_in     = '0;
         len_in     = '0;
         pcount_in  = '0;
         crc_in     = bpskdf_pkg::CRC_INIT;
         crc_lo_in  = '0;
         rcount_in  = '0;
         gbc_in     = '0;
         syncpos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= bpskdf_pkg::PH_HUNT;
         window_ff    <= '0;
         fill_ff      <= '0;
         bit_idx_ff   <= '0;
         shift_ff     <= '0;
         seq_ff       <= '0;
         len_ff       <= '0;
         pcount_ff    <= '0;
         crc_ff       <= bpskdf_pkg::CRC_INIT;
         crc_lo_ff    <= '0;
         rcount_ff    <= '0;
         gbc_ff       <= '0;
         syncpos_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         window_ff    <= window_in;
         fill_ff      <= fill_in;
         bit_idx_ff   <= bit_idx_in;
         shift_ff     <= shift_in;
         seq_ff       <= seq_in;
         len_ff       <= len_in;
         pcount_ff    <= pcount_in;
         crc_ff       <= crc_in;
         crc_lo_ff    <= crc_lo_in;
         rcount_ff    <= rcount_in;
         gbc_ff       <= gbc_in;
         syncpos_ff   <= syncpos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      rsp.valid             = rsp_valid_ff;
      rsp.result_kind       = rsp_ff.result_kind;
      rsp.data_byte         = rsp_ff.data_byte;
      rsp.sequence_number   = rsp_ff.sequence_number;
      rsp.payload_length    = rsp_ff.payload_length;
      rsp.crc_received      = rsp_ff.crc_received;
      rsp.crc_computed      = rsp_ff.crc_computed;
      rsp.crc_match         = rsp_ff.crc_match;
      rsp.sync_bit_position = rsp_ff.sync_bit_position;
      rsp.bytes_after_sync  = rsp_ff.bytes_after_sync;
   end

   a_hunt_aligned: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == bpskdf_pkg::PH_HUNT) |-> (bit_idx_ff == 3'd0))
      else $error("bit index not cleared while hunting");

   a_payload_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == bpskdf_pkg::PH_PAYLOAD) |-> (pcount_ff < len_ff))
      else $error("payload count reached length inside payload");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 4'd8)
      else $error("hunt fill count above window size");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("pending result lost or changed");

endmodule

@@ rtl/bpsk_slicer_packet_deframer_top.sv @@
// ----------------------------------------------------------------------------
// bpsk_slicer_packet_deframer_top
// BPSK sign slicer with sync-byte packet deframer and payload crc check.
// ----------------------------------------------------------------------------
//  channel | direction | handshake      | carries
//  req_ch  | in        | valid / ready  | one I/Q sample, end of capture flag
//  rsp_ch  | out       | valid / ready  | payload byte or packet report
//  csr     | in        | apb write/read | axis select, polarity, sync byte
//
//  one sample per clock sustained while the result port is ready, set by the one-bit deframer step
//  a result is registered in the back end after its sample leaves the slice queue
//  a stalled result port backs up the four-entry slice queue, then req ready
//  synchronous reset clears all but the queue entries and result fields, no clearing pass
// ----------------------------------------------------------------------------
module bpsk_slicer_packet_deframer_top #(
   parameter int SAMPLE_BITS   = bpskdf_pkg::SAMPLE_BITS_DEF,
   parameter int POSITION_BITS = bpskdf_pkg::POSITION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   bpskdf_req_if.sink                          req_ch,
   bpskdf_rsp_if.source                        rsp_ch,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bpskdf_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [bpskdf_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [bpskdf_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                pready
);

   bpskdf_pkg::cfg_type   cfg_ff, cfg_in;
   logic [1:0]            csr_index;
   logic                  csr_write;

   logic                  push_valid, push_ready;
   bpskdf_pkg::slice_type push_data;
   logic                  pop_valid, pop_ready;
   bpskdf_pkg::slice_type pop_data;

   always_comb begin
      pready    = 1'b1;
      csr_index = paddr[3:2];
      csr_write = psel && penable && pwrite && pready;
      cfg_in    = cfg_ff;
      prdata    = '0;
      unique case (csr_index)
         bpskdf_pkg::CSR_AXIS_SELECT: begin
            prdata[0] = cfg_ff.axis_select;
            if (csr_write) cfg_in.axis_select = pwdata[0];
         end
         bpskdf_pkg::CSR_INVERT_POLARITY: begin
            prdata[0] = cfg_ff.invert_polarity;
            if (csr_write) cfg_in.invert_polarity = pwdata[0];
         end
         bpskdf_pkg::CSR_SYNC_BYTE: begin
            prdata[7:0] = cfg_ff.sync_byte;
            if (csr_write) cfg_in.sync_byte = pwdata[7:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axis_select     <= 1'b0;
         cfg_ff.invert_polarity <= 1'b0;
         cfg_ff.sync_byte       <= bpskdf_pkg::SYNC_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bpskdf_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .cfg        (cfg_ff),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   bpskdf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   bpskdf_back #(
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp       (rsp_ch)
   );

endmodule

@@ tb/sv/bpskdf_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bpskdf_checker
// Watches the sample, result and register ports of the bpsk deframer, works
// out the expected payload bytes and packet reports for every accepted
// sample, and compares each result transfer with the oldest one due.
// ----------------------------------------------------------------------------
module bpskdf_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   bpskdf_req_if                                req_ch,
   bpskdf_rsp_if                                rsp_ch,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic                                 pready,
   input  logic [bpskdf_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [bpskdf_pkg::CSR_DATA_BITS-1:0] pwdata,
   output int                                   error_count,
   output int                                   pending_count
);

   bpskdf_pkg::cfg_type   link_cfg;
   bpskdf_pkg::rsp_type   awaited_reports[$];
   int                    errors = 0;

   // deframer state
   logic [7:0]            hunt_window;
   logic [3:0]            hunt_fill;
   bpskdf_pkg::phase_type deframe_phase;
   logic [2:0]            bit_index;
   logic [7:0]            byte_accum;
   logic [15:0]           seq_field;
   logic [7:0]            len_field;
   logic [7:0]            payload_seen;
   logic [15:0]           crc_running;
   logic [7:0]            crc_low_byte;
   logic [8:0]            bytes_seen;
   logic [31:0]           capture_bit;
   logic [31:0]           sync_pos;

   task automatic clear_deframer();
      hunt_window   = '0;
      hunt_fill     = '0;
      deframe_phase = bpskdf_pkg::PH_HUNT;
      bit_index     = '0;
      byte_accum    = '0;
      seq_field     = '0;
      len_field     = '0;
      payload_seen  = '0;
      crc_running   = bpskdf_pkg::CRC_INIT;
      crc_low_byte  = '0;
      bytes_seen    = '0;
      capture_bit   = '0;
      sync_pos      = '0;
   endtask

   task automatic check_field(input string field_name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %0h actual %0h", $time, field_name, want, got);
      end
   endtask

   always @(posedge clock) begin : predict_and_compare
      logic [15:0]         raw;
      logic                data_bit;
      logic [31:0]         pos;
      logic [7:0]          done_byte;
      logic                crc_fb;
      logic                emit;
      bpskdf_pkg::rsp_type fresh;
      bpskdf_pkg::rsp_type want;
      if (reset) begin
         link_cfg = '{1'b0, 1'b0, bpskdf_pkg::SYNC_RESET};
         clear_deframer();
         awaited_reports.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (bpskdf_pkg::csr_index_type'(paddr[bpskdf_pkg::CSR_ADDR_BITS-1:2]))
               bpskdf_pkg::CSR_AXIS_SELECT:     link_cfg.axis_select     = pwdata[0];
               bpskdf_pkg::CSR_INVERT_POLARITY: link_cfg.invert_polarity = pwdata[0];
               bpskdf_pkg::CSR_SYNC_BYTE:       link_cfg.sync_byte       = pwdata[7:0];
               default: ;
            endcase
         end

         if (req_ch.valid && req_ch.ready) begin
            raw = link_cfg.axis_select ? req_ch.sample_q : req_ch.sample_i;
            // inverted: only strictly positive gives a one, zero is always zero
            data_bit = link_cfg.invert_polarity ? (!raw[15] && raw != 16'h0000) : raw[15];
            pos = capture_bit;
            capture_bit = pos + 32'd1;
            emit = 1'b0;
            fresh = '0;

            if (deframe_phase == bpskdf_pkg::PH_HUNT) begin
               hunt_window = {hunt_window[6:0], data_bit};
               if (hunt_fill < 4'd8) hunt_fill++;
               if (hunt_fill >= 4'd8 && hunt_window == link_cfg.sync_byte) begin
                  sync_pos      = pos - 32'd7;
                  deframe_phase = bpskdf_pkg::PH_SEQ_LO;
                  bit_index     = '0;
                  byte_accum    = '0;
                  seq_field     = '0;
                  len_field     = '0;
                  payload_seen  = '0;
                  crc_running   = bpskdf_pkg::CRC_INIT;
                  crc_low_byte  = '0;
                  bytes_seen    = '0;
               end
            end else begin
               if (deframe_phase == bpskdf_pkg::PH_PAYLOAD) begin
                  crc_fb = crc_running[15] ^ data_bit;
                  crc_running = {crc_running[14:0], 1'b0} ^
                                (crc_fb ? bpskdf_pkg::CRC_POLY : 16'h0000);
               end
               byte_accum = {byte_accum[6:0], data_bit};
               if (bit_index == 3'd7) begin
                  done_byte  = byte_accum;
                  bit_index  = '0;
                  byte_accum = '0;
                  bytes_seen++;
                  case (deframe_phase)
                     bpskdf_pkg::PH_SEQ_LO: begin
                        seq_field     = {8'h00, done_byte};
                        deframe_phase = bpskdf_pkg::PH_SEQ_HI;
                     end
                     bpskdf_pkg::PH_SEQ_HI: begin
                        seq_field[15:8] = done_byte;
                        deframe_phase   = bpskdf_pkg::PH_LEN;
                     end
                     bpskdf_pkg::PH_LEN: begin
                        len_field     = done_byte;
                        deframe_phase = (done_byte != 8'h00) ? bpskdf_pkg::PH_PAYLOAD
                                                             : bpskdf_pkg::PH_CRC_LO;
                     end
                     bpskdf_pkg::PH_PAYLOAD: begin
                        emit              = 1'b1;
                        fresh.result_kind = bpskdf_pkg::KIND_PAYLOAD;
                        fresh.data_byte   = done_byte;
                        payload_seen++;
                        if (payload_seen == len_field) deframe_phase = bpskdf_pkg::PH_CRC_LO;
                     end
                     bpskdf_pkg::PH_CRC_LO: begin
                        crc_low_byte  = done_byte;
                        deframe_phase = bpskdf_pkg::PH_CRC_HI;
                     end
                     default: begin
                        emit               = 1'b1;
                        fresh.result_kind  = bpskdf_pkg::KIND_COMPLETE;
                        fresh.crc_received = {done_byte, crc_low_byte};
                        fresh.crc_computed = crc_running;
                        fresh.crc_match    = ({done_byte, crc_low_byte} == crc_running);
                        deframe_phase      = bpskdf_pkg::PH_HUNT;
                        hunt_window        = '0;
                        hunt_fill          = '0;
                     end
                  endcase
               end else begin
                  bit_index++;
               end
            end

            // a cut inside the body replaces any payload byte of the same sample
            if (req_ch.end_of_capture && (deframe_phase == bpskdf_pkg::PH_PAYLOAD ||
                deframe_phase == bpskdf_pkg::PH_CRC_LO ||
                deframe_phase == bpskdf_pkg::PH_CRC_HI)) begin
               emit = 1'b1;
               fresh = '0;
               fresh.result_kind = bpskdf_pkg::KIND_TRUNCATED;
            end
            if (emit) begin
               fresh.sequence_number   = seq_field;
               fresh.payload_length    = len_field;
               fresh.sync_bit_position = sync_pos;
               fresh.bytes_after_sync  = bytes_seen;
               awaited_reports.push_back(fresh);
            end
            if (req_ch.end_of_capture) clear_deframer();
         end

         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_reports.size() == 0) begin
               errors++;
               $display("%0t: result expected none actual kind %0d byte %0h", $time,
                        rsp_ch.result_kind, rsp_ch.data_byte);
            end else begin
               want = awaited_reports.pop_front();
               check_field("result_kind", 32'(want.result_kind), 32'(rsp_ch.result_kind));
               check_field("data_byte", 32'(want.data_byte), 32'(rsp_ch.data_byte));
               check_field("sequence_number", 32'(want.sequence_number),
                           32'(rsp_ch.sequence_number));
               check_field("payload_length", 32'(want.payload_length),
                           32'(rsp_ch.payload_length));
               check_field("crc_received", 32'(want.crc_received), 32'(rsp_ch.crc_received));
               check_field("crc_computed", 32'(want.crc_computed), 32'(rsp_ch.crc_computed));
               check_field("crc_match", 32'(want.crc_match), 32'(rsp_ch.crc_match));
               check_field("sync_bit_position", want.sync_bit_position,
                           rsp_ch.sync_bit_position);
               check_field("bytes_after_sync", 32'(want.bytes_after_sync),
                           32'(rsp_ch.bytes_after_sync));
            end
         end
      end
      error_count   <= errors;
      pending_count <= awaited_reports.size();
   end

endmodule

@@ tb/sv/bpsk_slicer_packet_deframer_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bpsk_slicer_packet_deframer_top_tb
// Drives sliced-bit packets, noise and capture cuts into the deframer under
// several axis, polarity and sync settings with random idling on both
// channels; the checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module bpsk_slicer_packet_deframer_top_tb;

   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam int SEG_ITEMS    = 16;

   logic                                 clock;
   logic                                 reset;
   logic                                 psel;
   logic                                 penable;
   logic                                 pwrite;
   logic [bpskdf_pkg::CSR_ADDR_BITS-1:0] paddr;
   logic [bpskdf_pkg::CSR_DATA_BITS-1:0] pwdata;
   logic [bpskdf_pkg::CSR_DATA_BITS-1:0] prdata;
   logic                                 pready;

   int                  error_count;
   int                  pending_count;
   int                  req_idle_pct;
   int                  rsp_idle_pct;
   int                  hold_requests;
   int                  sent_items;
   bpskdf_pkg::cfg_type link_cfg;

   bpskdf_req_if req_ch ();
   bpskdf_rsp_if rsp_ch ();

   bpsk_slicer_packet_deframer_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   bpskdf_checker deframe_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   task automatic send_sample(input logic [15:0] si, input logic [15:0] sq,
                              input logic eoc);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.sample_i       <= si;
      req_ch.sample_q       <= sq;
      req_ch.end_of_capture <= eoc;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_items++;
   endtask

   // pick a sample on the sliced axis that gives the wanted bit
   task automatic send_bit(input logic data_bit, input logic eoc);
      logic [14:0] r;
      logic [15:0] chosen;
      logic [15:0] other;
      r = 15'($urandom_range(32767));
      if ($urandom_range(7) == 0) r = ($urandom_range(1) != 0) ? 15'h7FFF : 15'h0000;
      if (!link_cfg.invert_polarity)
         chosen = {data_bit, r};
      else if (data_bit)
         chosen = {1'b0, (r == 15'h0000) ? 15'h0001 : r};
      else
         chosen = ($urandom_range(5) == 0) ? 16'h0000 : {1'b1, r};
      other = 16'($urandom);
      if (link_cfg.axis_select) send_sample(other, chosen, eoc);
      else                      send_sample(chosen, other, eoc);
   endtask

   // cut_at: bit index from the first sync bit that carries end of capture,
   // the rest of the packet is dropped; negative for a whole packet
   task automatic send_packet(input int length, input logic good_crc, input int cut_at);
      logic [7:0]  frame_bytes[$];
      logic [15:0] seq;
      logic [15:0] crc;
      logic [7:0]  payload_byte;
      logic        fb;
      int          nbit;
      seq = 16'($urandom);
      crc = bpskdf_pkg::CRC_INIT;
      frame_bytes = {link_cfg.sync_byte, seq[7:0], seq[15:8], 8'(length)};
      repeat (length) begin
         payload_byte = 8'($urandom);
         frame_bytes.push_back(payload_byte);
         for (int b = 7; b >= 0; b--) begin
            fb  = crc[15] ^ payload_byte[b];
            crc = {crc[14:0], 1'b0} ^ (fb ? bpskdf_pkg::CRC_POLY : 16'h0000);
         end
      end
      if (!good_crc) crc = crc ^ (16'h0001 << $urandom_range(15));
      frame_bytes.push_back(crc[7:0]);
      frame_bytes.push_back(crc[15:8]);
      nbit = 0;
      foreach (frame_bytes[k]) begin
         for (int b = 7; b >= 0; b--) begin
            if (cut_at < 0 || nbit <= cut_at) send_bit(frame_bytes[k][b], nbit == cut_at);
            nbit++;
         end
      end
   endtask

   task automatic write_csr(input bpskdf_pkg::csr_index_type index,
                            input logic [7:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= {24'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      case (index)
         bpskdf_pkg::CSR_AXIS_SELECT:     link_cfg.axis_select     = value[0];
         bpskdf_pkg::CSR_INVERT_POLARITY: link_cfg.invert_polarity = value[0];
         bpskdf_pkg::CSR_SYNC_BYTE:       link_cfg.sync_byte       = value;
         default: ;
      endcase
   endtask

   // wait for every due result, then let samples that give none flow out
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : receiver
      int holds_done;
      holds_done = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests > holds_done) begin
            holds_done++;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   initial begin : stimulus
      int                  seg;
      int                  seg_start;
      int                  length;
      int                  total_bits;
      int                  cut;
      bpskdf_pkg::cfg_type seg_cfg;
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.sample_i       = '0;
      req_ch.sample_q       = '0;
      req_ch.end_of_capture = 1'b0;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      req_idle_pct          = 13;
      rsp_idle_pct          = 47;
      hold_requests         = 0;
      sent_items            = 0;
      link_cfg              = '{1'b0, 1'b0, bpskdf_pkg::SYNC_RESET};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sample extremes on both axes
      send_sample(16'h0000, 16'h0000, 1'b0);
      send_sample(16'h8000, 16'h7FFF, 1'b0);
      send_sample(16'h7FFF, 16'h8000, 1'b0);
      send_sample(16'hFFFF, 16'h0001, 1'b0);
      send_sample(16'h0001, 16'hFFFF, 1'b0);
      // zero length, capture ends on the last crc bit
      send_packet(0, 1'b1, 47);
      send_packet(2, 1'b1, -1);
      send_packet(1, 1'b0, -1);
      // capture ends inside the header
      send_packet(3, 1'b1, 20);
      // capture ends on the bit that completes a payload byte
      send_packet(4, 1'b1, 39);
      // capture ends inside the crc
      send_packet(1, 1'b1, 43);
      // capture ends while hunting
      send_sample(16'($urandom), 16'($urandom), 1'b1);

      for (seg = 0; seg < 6; seg++) begin
         settle();
         req_idle_pct = (seg < 2) ? 13 : (seg < 4) ? 47 : 0;
         rsp_idle_pct = (seg < 2) ? 47 : (seg < 4) ? 13 : 0;
         case (seg)
            0:       seg_cfg = '{1'b1, 1'b0, bpskdf_pkg::SYNC_RESET};
            1:       seg_cfg = '{1'b0, 1'b1, 8'h00};
            2:       seg_cfg = '{1'b1, 1'b1, 8'hFF};
            3:       seg_cfg = '{1'b0, 1'b0, 8'($urandom)};
            4:       seg_cfg = '{1'b1, 1'b0, 8'($urandom)};
            default: seg_cfg = '{1'b0, 1'b1, bpskdf_pkg::SYNC_RESET};
         endcase
         write_csr(bpskdf_pkg::CSR_AXIS_SELECT, {7'd0, seg_cfg.axis_select});
         write_csr(bpskdf_pkg::CSR_INVERT_POLARITY, {7'd0, seg_cfg.invert_polarity});
         write_csr(bpskdf_pkg::CSR_SYNC_BYTE, seg_cfg.sync_byte);

         // long receiver stall while a packet keeps streaming in
         if (seg == 1 || seg == 4) begin
            // start from a clean hunt so the packet surely gives results
            send_sample(16'($urandom), 16'($urandom), 1'b1);
            hold_requests++;
            send_packet(2, 1'b1, -1);
         end

         seg_start = sent_items;
         while (sent_items - seg_start < SEG_ITEMS) begin
            if ($urandom_range(9) < 2) begin
               repeat ($urandom_range(6, 1))
                  send_sample(16'($urandom), 16'($urandom), $urandom_range(7) == 0);
            end else begin
               length = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(4);
               total_bits = 8 * (length + 6);
               case ($urandom_range(9))
                  0, 1:    cut = $urandom_range(total_bits - 1);
                  2:       cut = total_bits - 1;
                  default: cut = -1;
               endcase
               send_packet(length, $urandom_range(4) != 0, cut);
            end
         end
         // largest length field, cut on the last bit of the second payload byte
         if (seg == 5) send_packet(255, 1'b1, 47);
      end

      settle();
      if (error_count == 0 && pending_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin : watchdog
      #1000000;
      $display("status: fail");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/bpskdf_pkg.sv
rtl/bpskdf_ifs.sv
rtl/bpskdf_front.sv
rtl/bpskdf_queue.sv
rtl/bpskdf_back.sv
rtl/bpsk_slicer_packet_deframer_top.sv
tb/sv/bpskdf_checker.sv
tb/sv/bpsk_slicer_packet_deframer_top_tb.sv
